@@ rtl/core/htfcrc_pkg.sv @@
package htfcrc_pkg;

  // CRC-8 settings of the sensor reply
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte positions within a six-byte frame
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // Conversion constants: value = floor((k*raw + FS) / FS) / 2
  localparam int unsigned ACC_W = 25;
  localparam logic [ACC_W-1:0] FULL_SCALE = 25'd65535;
  localparam logic [ACC_W-1:0] TEMP_SCALE = 25'd350;
  localparam logic [ACC_W-1:0] HUM_SCALE  = 25'd200;
  localparam logic signed [8:0] TEMP_OFFSET = 9'sd45;

  // Queue depth between front and back
  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  // One checked frame
  typedef struct packed {
    logic        ok;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
  } frame_t;

  // Queue write side
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } q_push_t;

  // Queue read side
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } q_head_t;

  // Advance a CRC-8 over one byte, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/htfcrc_front.sv @@
module htfcrc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  output htfcrc_pkg::q_push_t push
);
  import htfcrc_pkg::*;

  logic [2:0]  byte_pos;
  logic [7:0]  running_crc;
  logic [15:0] temp_word;
  logic [15:0] hum_word;
  logic        first_good;

  logic [2:0]  pos;
  logic [7:0]  crc_base;
  logic [7:0]  crc_upd;

  // Resolve position and CRC seed for this byte
  always_comb begin
    pos      = (frame_start || byte_pos > POS_H_CRC) ? POS_T_HI : byte_pos;
    crc_base = (pos == POS_T_HI || pos == POS_H_HI) ? CRC_INIT : running_crc;
    crc_upd  = crc8_byte(crc_base, rx_byte);
  end

  // Emit a checked frame on its last byte
  always_comb begin
    push.valid           = accept && (pos == POS_H_CRC);
    push.frame.ok        = first_good && (running_crc == rx_byte);
    push.frame.temp_word = temp_word;
    push.frame.hum_word  = hum_word;
  end

  // Assemble words and track checksums
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos    <= POS_T_HI;
      running_crc <= CRC_INIT;
      temp_word   <= 16'h0000;
      hum_word    <= 16'h0000;
      first_good  <= 1'b0;
    end else if (accept) begin
      byte_pos <= (pos == POS_H_CRC) ? POS_T_HI : pos + 3'd1;
      unique case (pos)
        POS_T_HI: begin
          temp_word   <= {rx_byte, 8'h00};
          running_crc <= crc_upd;
        end
        POS_T_LO: begin
          temp_word[7:0] <= rx_byte;
          running_crc    <= crc_upd;
        end
        POS_T_CRC: begin
          first_good <= (crc_base == rx_byte);
        end
        POS_H_HI: begin
          hum_word    <= {rx_byte, 8'h00};
          running_crc <= crc_upd;
        end
        POS_H_LO: begin
          hum_word[7:0] <= rx_byte;
          running_crc   <= crc_upd;
        end
        default: begin
          // last checksum byte closes the frame
        end
      endcase
    end
  end

endmodule

@@ rtl/core/htfcrc_queue.sv @@
module htfcrc_queue (
  input  logic                clk,
  input  logic                rst,
  input  htfcrc_pkg::q_push_t push,
  input  logic                pop,
  output htfcrc_pkg::q_head_t head,
  output logic                full
);
  import htfcrc_pkg::*;

  frame_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign full       = (count == QUEUE_DEPTH);
  assign head.valid = (count != 2'd0);
  assign head.frame = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  // Store pushed frames
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.frame;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push.valid} - {1'b0, do_pop};
    end
  end

endmodule

@@ rtl/core/htfcrc_back.sv @@
module htfcrc_back (
  input  logic                clk,
  input  logic                rst,
  input  htfcrc_pkg::q_head_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                status,
  output logic [15:0]         raw_temperature,
  output logic [15:0]         raw_humidity,
  output logic signed [8:0]   temperature_c,
  output logic [6:0]          humidity_pct
);
  import htfcrc_pkg::*;

  logic             s1_valid;
  logic             s1_ok;
  logic [15:0]      s1_tw;
  logic [15:0]      s1_hw;
  logic [ACC_W-1:0] s1_mt;
  logic [ACC_W-1:0] s1_mh;

  logic             s2_ready;
  logic             s1_ready;
  logic [7:0]       temp_whole;
  logic [7:0]       hum_whole;

  // floor(m / 65535) via shift and one correction, then halve
  function automatic logic [7:0] half_quot(input logic [ACC_W-1:0] m);
    logic [8:0]  q0;
    logic [16:0] r;
    logic [8:0]  q;
    q0 = m[ACC_W-1:16];
    r  = {1'b0, m[15:0]} + {8'd0, q0};
    q  = q0 + {8'd0, (r >= FULL_SCALE[16:0])};
    return q[8:1];
  endfunction

  assign s2_ready = !out_valid || !out_stall;
  assign s1_ready = !s1_valid || s2_ready;
  assign pop      = s1_ready && head.valid;

  assign temp_whole = half_quot(s1_mt);
  assign hum_whole  = half_quot(s1_mh);

  // Stage one: scale and bias
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_ok <= head.frame.ok;
      s1_tw <= head.frame.temp_word;
      s1_hw <= head.frame.hum_word;
      s1_mt <= ACC_W'(head.frame.temp_word) * TEMP_SCALE + FULL_SCALE;
      s1_mh <= ACC_W'(head.frame.hum_word) * HUM_SCALE + FULL_SCALE;
    end
  end

  // Stage two: divide, offset and hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      status <= !s1_ok;
      if (s1_ok) begin
        raw_temperature <= s1_tw;
        raw_humidity    <= s1_hw;
        temperature_c   <= $signed({1'b0, temp_whole}) - TEMP_OFFSET;
        humidity_pct    <= hum_whole[6:0];
      end else begin
        raw_temperature <= 16'd0;
        raw_humidity    <= 16'd0;
        temperature_c   <= 9'sd0;
        humidity_pct    <= 7'd0;
      end
    end
  end

endmodule

@@ rtl/core/humidity_temp_frame_crc_decoder.sv @@
// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid / in_stall  | rx_byte, frame_start
// result  | out       | out_valid / out_stall| status, raw_temperature, raw_humidity,
//         |           |                      | temperature_c, humidity_pct
//
// A byte is taken per cycle unless stalled; the front CRC unit handles a whole byte combinationally.
// After the sixth byte the frame passes the queue, the scale stage, then the divide stage, each registered.
// Reset (rst, synchronous) empties the queue and pipeline and restarts at the first byte.
// in_stall rises only when the two-entry frame queue is full; out_stall holds the result.
module humidity_temp_frame_crc_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              frame_start,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              status,
  output logic [15:0]       raw_temperature,
  output logic [15:0]       raw_humidity,
  output logic signed [8:0] temperature_c,
  output logic [6:0]        humidity_pct
);
  import htfcrc_pkg::*;

  q_push_t push;
  q_head_t head;
  logic    pop;
  logic    full;
  logic    accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  htfcrc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .push        (push)
  );

  htfcrc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (full)
  );

  htfcrc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .raw_temperature (raw_temperature),
    .raw_humidity    (raw_humidity),
    .temperature_c   (temperature_c),
    .humidity_pct    (humidity_pct)
  );

endmodule

@@ rtl/core/htfcrc_checker.sv @@
module htfcrc_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              status,
  input logic [15:0]       raw_temperature,
  input logic [15:0]       raw_humidity,
  input logic signed [8:0] temperature_c,
  input logic [6:0]        humidity_pct
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(raw_temperature)
      && $stable(raw_humidity) && $stable(temperature_c) && $stable(humidity_pct))
    else $error("stalled result changed");

  // Drop results after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // Zero all fields on a checksum error
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> raw_temperature == 16'd0 && raw_humidity == 16'd0
      && temperature_c == 9'sd0 && humidity_pct == 7'd0)
    else $error("error result carries data");

  // Keep converted temperature in sensor range
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> temperature_c >= -9'sd45 && temperature_c <= 9'sd130)
    else $error("temperature out of range");

  // Keep converted humidity in range
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> humidity_pct <= 7'd100)
    else $error("humidity out of range");

endmodule

bind humidity_temp_frame_crc_decoder htfcrc_checker u_htfcrc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .status          (status),
  .raw_temperature (raw_temperature),
  .raw_humidity    (raw_humidity),
  .temperature_c   (temperature_c),
  .humidity_pct    (humidity_pct)
);
